### rtl/apt2d_pkg.sv
// Package for the 2-D affine vertex transform: payload structs, register indexes,
// fixed-point widths, trig sequencer states and the truncate/saturate helpers.
// No dependencies.
package apt2d_pkg;

  localparam int COORD_BITS     = 12;
  localparam int TRIG_FRAC_BITS = 16;
  localparam int TRIG_W         = TRIG_FRAC_BITS + 2;
  localparam int OUT_W          = 16;
  localparam int SCALE_W        = 16;
  localparam int SCALE_FRAC     = 8;
  localparam int ANGLE_W        = 14;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  localparam int ROT_PROD_W = COORD_BITS + TRIG_W;
  localparam int ROT_SUM_W  = ROT_PROD_W + 2;
  localparam int SCL_PROD_W = COORD_BITS + SCALE_W;
  localparam int WIDE_W     = 48;

  // Q30 trig engine
  localparam int Q_BITS       = 30;
  localparam int RND_SH       = Q_BITS - TRIG_FRAC_BITS;
  localparam int FULL_TURN    = 5760;
  localparam int QUARTER_TURN = 1440;
  localparam int EIGHTH_TURN  = 720;
  localparam logic [30:0] RAD_PER_UNIT_Q40 = 31'd1199381129;
  localparam logic [30:0] Q30_ONE = 31'(1) << Q_BITS;

  localparam logic [1:0] MODE_TRANSLATE = 2'd0;
  localparam logic [1:0] MODE_ROTATE    = 2'd1;
  localparam logic [1:0] MODE_SCALE     = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOCKWISE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_X   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Y   = 3'd6;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x_in;
    logic signed [COORD_BITS-1:0] y_in;
    logic                         last_vertex;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x_out;
    logic signed [OUT_W-1:0] y_out;
    logic                    last_out;
  } out_item_t;

  typedef struct packed {
    logic                     ready;
    logic signed [TRIG_W-1:0] cos_value;
    logic signed [TRIG_W-1:0] sin_value;
  } trig_status_t;

  typedef enum logic [3:0] {
    T_IDLE, T_LOAD, T_RED, T_FOLD, T_UMUL, T_UFIX, T_SQ, T_SQFIX,
    T_HMUL, T_DIV0, T_DIV, T_HUPD, T_SMUL, T_SFIX, T_FIN
  } trig_state_t;

  localparam logic [2:0] SIN_TERMS = 3'd5;
  localparam logic [2:0] COS_TERMS = 3'd6;

  // Horner divisors 110,72,42,20,6 (sine) and 132,90,56,30,12,2 (cosine) as
  // ceil(2^s / d) with s = 30 + ceil(log2 d): exact floor for dividends below 2^30
  function automatic logic [30:0] horner_recip(input logic cos_phase, input logic [2:0] k);
    logic [30:0] m;
    m = 31'd1;
    if (!cos_phase) begin
      case (k)
        3'd0:    m = 31'd1249445032;
        3'd1:    m = 31'd1908874354;
        3'd2:    m = 31'd1636178018;
        3'd3:    m = 31'd1717986919;
        default: m = 31'd1431655766;
      endcase
    end else begin
      case (k)
        3'd0:    m = 31'd2082408386;
        3'd1:    m = 31'd1527099484;
        3'd2:    m = 31'd1227133514;
        3'd3:    m = 31'd1145324613;
        3'd4:    m = 31'd1431655766;
        default: m = 31'd1073741824;
      endcase
    end
    return m;
  endfunction

  function automatic logic [5:0] horner_shift(input logic cos_phase, input logic [2:0] k);
    logic [5:0] s;
    s = 6'd31;
    if (!cos_phase) begin
      case (k)
        3'd0:    s = 6'd37;
        3'd1:    s = 6'd37;
        3'd2:    s = 6'd36;
        3'd3:    s = 6'd35;
        default: s = 6'd33;
      endcase
    end else begin
      case (k)
        3'd0:    s = 6'd38;
        3'd1:    s = 6'd37;
        3'd2:    s = 6'd36;
        3'd3:    s = 6'd35;
        3'd4:    s = 6'd34;
        default: s = 6'd31;
      endcase
    end
    return s;
  endfunction

  // truncate toward zero, dropping f fraction bits
  function automatic logic signed [WIDE_W-1:0] trunc_fz(input logic signed [WIDE_W-1:0] v,
                                                        input int f);
    logic signed [WIDE_W-1:0] bias;
    bias = v[WIDE_W-1] ? ((WIDE_W'(1) <<< f) - WIDE_W'(1)) : '0;
    return (v + bias) >>> f;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat16(input logic signed [WIDE_W-1:0] v);
    logic signed [OUT_W-1:0] r;
    if (v > WIDE_W'(32767))       r = 16'sh7FFF;
    else if (v < -WIDE_W'(32768)) r = 16'sh8000;
    else                          r = v[OUT_W-1:0];
    return r;
  endfunction

endpackage

### rtl/apt2d_trig.sv
// Sine/cosine sequencer: quadrant reduction, Taylor series in Q30 on a shared
// multiplier with reciprocal-multiply division, rounded to Q1.TRIG_FRAC_BITS. Uses apt2d_pkg.
module apt2d_trig import apt2d_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      restart,
  input  logic signed [ANGLE_W-1:0] angle,
  output trig_status_t              status
);

  trig_state_t state, state_next;

  logic [14:0] acc;
  logic [1:0]  quad;
  logic        swap;
  logic [9:0]  rr;
  logic [29:0] u;
  logic [29:0] x2;
  logic [30:0] t;
  logic [30:0] s30;
  logic [60:0] prod;
  logic        phase;
  logic [2:0]  k;
  logic [30:0] dnum;

  logic                     ready;
  logic signed [TRIG_W-1:0] cos_value, sin_value;

  logic [30:0] mul_a, mul_b;
  logic [30:0] recip;
  logic [5:0]  rsh;
  logic [2:0]  terms;
  logic [31:0] s_sum, c_sum;
  logic signed [TRIG_W-1:0] s_tr, c_tr, s_q, c_q;

  assign recip   = horner_recip(phase, k);
  assign rsh     = horner_shift(phase, k);
  assign terms   = phase ? COS_TERMS : SIN_TERMS;
  assign s_sum   = 32'(s30) + 32'(32'd1 << (RND_SH - 1));
  assign c_sum   = 32'(t)   + 32'(32'd1 << (RND_SH - 1));
  assign s_tr    = TRIG_W'(s_sum >> RND_SH);
  assign c_tr    = TRIG_W'(c_sum >> RND_SH);
  assign s_q     = swap ? c_tr : s_tr;
  assign c_q     = swap ? s_tr : c_tr;

  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE:  state_next = T_IDLE;
      T_LOAD:  state_next = T_RED;
      T_RED:   if (acc < 15'(QUARTER_TURN)) state_next = T_FOLD;
      T_FOLD:  state_next = T_UMUL;
      T_UMUL:  state_next = T_UFIX;
      T_UFIX:  state_next = T_SQ;
      T_SQ:    state_next = T_SQFIX;
      T_SQFIX: state_next = T_HMUL;
      T_HMUL:  state_next = T_DIV0;
      T_DIV0:  state_next = T_DIV;
      T_DIV:   state_next = T_HUPD;
      T_HUPD: begin
        if (k == terms - 3'd1) state_next = phase ? T_FIN : T_SMUL;
        else                   state_next = T_HMUL;
      end
      T_SMUL:  state_next = T_SFIX;
      T_SFIX:  state_next = T_HMUL;
      T_FIN:   state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      T_UMUL: begin
        mul_a = 31'(rr);
        mul_b = RAD_PER_UNIT_Q40;
      end
      T_SQ: begin
        mul_a = 31'(u);
        mul_b = 31'(u);
      end
      T_HMUL: begin
        mul_a = 31'(x2);
        mul_b = t;
      end
      T_DIV: begin
        mul_a = dnum;
        mul_b = recip;
      end
      T_SMUL: begin
        mul_a = 31'(u);
        mul_b = t;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= T_LOAD;
      ready <= 1'b0;
    end else begin
      state <= state_next;
      if (state == T_FIN) ready <= 1'b1;
    end
    if (rst) begin
      cos_value <= '0;
      sin_value <= '0;
    end else if (!restart && state == T_FIN) begin
      unique case (quad)
        2'd0: begin
          cos_value <= c_q;
          sin_value <= s_q;
        end
        2'd1: begin
          cos_value <= -s_q;
          sin_value <= c_q;
        end
        2'd2: begin
          cos_value <= -c_q;
          sin_value <= -s_q;
        end
        default: begin
          cos_value <= s_q;
          sin_value <= -c_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == T_UMUL || state == T_SQ || state == T_HMUL || state == T_DIV ||
        state == T_SMUL)
      prod <= 61'(mul_a * mul_b);
    case (state)
      T_LOAD: begin
        acc  <= 15'(16'(angle) + 16'(2 * FULL_TURN));
        quad <= 2'd0;
      end
      T_RED: begin
        if (acc >= 15'(QUARTER_TURN)) begin
          acc  <= acc - 15'(QUARTER_TURN);
          quad <= quad + 2'd1;
        end
      end
      T_FOLD: begin
        if (acc <= 15'(EIGHTH_TURN)) begin
          rr   <= 10'(acc);
          swap <= 1'b0;
        end else begin
          rr   <= 10'(15'(QUARTER_TURN) - acc);
          swap <= 1'b1;
        end
      end
      T_UFIX:  u <= 30'((prod + 61'd512) >> 10);
      T_SQFIX: begin
        x2    <= 30'(prod >> Q_BITS);
        t     <= Q30_ONE;
        k     <= '0;
        phase <= 1'b0;
      end
      T_DIV0:  dnum <= prod[60:30];
      T_HUPD: begin
        t <= Q30_ONE - 31'(prod >> rsh);
        k <= k + 3'd1;
      end
      T_SFIX: begin
        s30   <= 31'(prod >> Q_BITS);
        t     <= Q30_ONE;
        k     <= '0;
        phase <= 1'b1;
      end
      default: ;
    endcase
  end

  assign status = '{ready: ready, cos_value: cos_value, sin_value: sin_value};

endmodule

### rtl/affine_point_transform_2d_core.sv
// Top level of the 2-D homogeneous affine vertex transform: config registers and
// a three-stage transform pipeline. Uses apt2d_pkg and apt2d_trig.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   in_item  (in_item_t)
//  out      source     out_valid / out_stall out_item (out_item_t)
//  cfg      sink       cfg_valid / cfg_ready cfg_index, cfg_data
//
// One vertex per cycle when not stalled; a vertex passes stage registers 1, 2, 3 in turn.
// Every register write restarts the sine/cosine sequencer, which runs its reduction loop
// then eleven Horner steps, each T_HMUL, T_DIV0, T_DIV, T_HUPD; inputs stall meanwhile.
// The same happens once after reset. A stalled output with a valid result freezes all stages.
module affine_point_transform_2d_core import apt2d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [1:0]                   mode;
  logic signed [COORD_BITS-1:0] shift_x, shift_y;
  logic signed [ANGLE_W-1:0]    angle;
  logic                         clockwise;
  logic signed [SCALE_W-1:0]    scale_x, scale_y;

  logic         cfg_write;
  trig_status_t trig;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready && (cfg_index <= CFG_SCALE_Y);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_TRANSLATE;
      shift_x   <= '0;
      shift_y   <= '0;
      angle     <= '0;
      clockwise <= 1'b0;
      scale_x   <= 16'sd256;
      scale_y   <= 16'sd256;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MODE:      mode      <= cfg_data[1:0];
        CFG_SHIFT_X:   shift_x   <= cfg_data[COORD_BITS-1:0];
        CFG_SHIFT_Y:   shift_y   <= cfg_data[COORD_BITS-1:0];
        CFG_ANGLE:     angle     <= cfg_data[ANGLE_W-1:0];
        CFG_CLOCKWISE: clockwise <= cfg_data[0];
        CFG_SCALE_X:   scale_x   <= cfg_data[SCALE_W-1:0];
        CFG_SCALE_Y:   scale_y   <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  apt2d_trig u_trig (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_write),
    .angle   (angle),
    .status  (trig)
  );

  logic adv, accept;
  logic v1, v2, v3;

  assign adv      = !v3 || !out_stall;
  assign in_stall = !adv || !trig.ready;
  assign accept   = in_valid && !in_stall;

  // stage 1: products
  logic signed [TRIG_W-1:0]     s_eff;
  logic signed [ROT_PROD_W-1:0] px_c, py_s, px_s, py_c;
  logic signed [SCL_PROD_W-1:0] psx, psy;
  logic signed [COORD_BITS-1:0] x1, y1;
  logic                         last1;

  assign s_eff = clockwise ? -trig.sin_value : trig.sin_value;

  always_ff @(posedge clk) begin
    if (adv) begin
      px_c  <= ROT_PROD_W'(in_item.x_in * trig.cos_value);
      py_s  <= ROT_PROD_W'(in_item.y_in * s_eff);
      px_s  <= ROT_PROD_W'(in_item.x_in * s_eff);
      py_c  <= ROT_PROD_W'(in_item.y_in * trig.cos_value);
      psx   <= SCL_PROD_W'(in_item.x_in * scale_x);
      psy   <= SCL_PROD_W'(in_item.y_in * scale_y);
      x1    <= in_item.x_in;
      y1    <= in_item.y_in;
      last1 <= in_item.last_vertex;
    end
  end

  // stage 2: first truncation and running sums
  logic signed [WIDE_W-1:0]     xt1, yt1;
  logic signed [ROT_SUM_W-1:0]  xa, ya;
  logic signed [WIDE_W-1:0]     sxt, syt;
  logic signed [COORD_BITS:0]   tx2, ty2;
  logic signed [COORD_BITS-1:0] x2, y2;
  logic                         last2;

  assign xt1 = trunc_fz(WIDE_W'(px_c), TRIG_FRAC_BITS);
  assign yt1 = trunc_fz(WIDE_W'(px_s), TRIG_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (adv) begin
      xa    <= ROT_SUM_W'((xt1 <<< TRIG_FRAC_BITS) - WIDE_W'(py_s));
      ya    <= ROT_SUM_W'((yt1 <<< TRIG_FRAC_BITS) + WIDE_W'(py_c));
      sxt   <= trunc_fz(WIDE_W'(psx), SCALE_FRAC);
      syt   <= trunc_fz(WIDE_W'(psy), SCALE_FRAC);
      tx2   <= (COORD_BITS+1)'(x1) + (COORD_BITS+1)'(shift_x);
      ty2   <= (COORD_BITS+1)'(y1) + (COORD_BITS+1)'(shift_y);
      x2    <= x1;
      y2    <= y1;
      last2 <= last1;
    end
  end

  // stage 3: mode select and saturation
  logic signed [WIDE_W-1:0] xsel, ysel;

  always_comb begin
    case (mode)
      MODE_TRANSLATE: begin
        xsel = WIDE_W'(tx2);
        ysel = WIDE_W'(ty2);
      end
      MODE_ROTATE: begin
        xsel = trunc_fz(WIDE_W'(xa), TRIG_FRAC_BITS);
        ysel = trunc_fz(WIDE_W'(ya), TRIG_FRAC_BITS);
      end
      MODE_SCALE: begin
        xsel = sxt;
        ysel = syt;
      end
      default: begin
        xsel = WIDE_W'(x2);
        ysel = WIDE_W'(y2);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.x_out    <= sat16(xsel);
      out_item.y_out    <= sat16(ysel);
      out_item.last_out <= last2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (adv) begin
      v1 <= accept;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign out_valid = v3;

  a_accept_trig_ready: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |-> trig.ready)
    else $error("vertex taken before sine/cosine ready");

  a_cfg_restarts_trig: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready && cfg_index <= CFG_SCALE_Y |=> !trig.ready)
    else $error("register write did not restart trig sequencer");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    v2 && !adv |=> v2 && v3)
    else $error("pipeline stage lost during stall");

  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    v3 && out_stall |-> in_stall)
    else $error("input taken while output stalled");

endmodule
